@@ rtl/core/shs_pkg.sv @@
// shs_pkg: shared types, round constants and initial hash values for the
// SHA-256 stream hasher. No dependencies; used by shs_round and the top level.
package shs_pkg;

  localparam int WORD_W = 32;
  localparam int HASH_WORDS = 8;
  localparam int BLOCK_BYTES = 64;
  localparam int ROUNDS = 64;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t hash_t [HASH_WORDS];

  // schedule window taps: w[t], w[t+1], w[t+9], w[t+14]
  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w9;
    word_t w14;
  } taps_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_FOLD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam hash_t INIT_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

@@ rtl/core/shs_round.sv @@
// shs_round: one SHA-256 compression round plus one message schedule word.
// Combinational; reused every round by the top-level sequencer. Uses shs_pkg.
module shs_round (
  input  shs_pkg::hash_t v,
  input  shs_pkg::word_t k,
  input  shs_pkg::taps_t taps,
  output shs_pkg::hash_t v_next,
  output shs_pkg::word_t w_new
);

  function automatic shs_pkg::word_t big_s0(input shs_pkg::word_t x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic shs_pkg::word_t big_s1(input shs_pkg::word_t x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic shs_pkg::word_t small_s0(input shs_pkg::word_t x);
    small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic shs_pkg::word_t small_s1(input shs_pkg::word_t x);
    small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  shs_pkg::word_t ch;
  shs_pkg::word_t maj;
  shs_pkg::word_t t1;
  shs_pkg::word_t t2;

  always_comb begin
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + big_s1(v[4]) + ch + k + taps.w0;
    t2  = big_s0(v[0]) + maj;
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
    w_new = small_s1(taps.w14) + taps.w9 + small_s0(taps.w1) + taps.w0;
  end

endmodule

@@ rtl/core/sha256_stream_hasher_core.sv @@
// sha256_stream_hasher_core: byte-stream SHA-256 with padding and digest output.
// Depends on shs_pkg and shs_round (one round per cycle, shared for all rounds).
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------
//   in       | in_valid / in_ready | kind, data_byte
//   out      | out_valid/out_ready | digest_word, word_index, last
//
// A data beat is taken while idle; every 64th byte starts 64 rounds and a fold
// in the shared round unit before the next byte is taken.
// A finish beat emits padding one byte per cycle (up to 64, or 72 with an
// extra block), compresses once or twice, then presents 8 digest beats.
// in_ready is high only while idle. Sync reset restores the initial hash.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);

  shs_pkg::state_t state;
  shs_pkg::hash_t  hash;
  shs_pkg::hash_t  v;
  shs_pkg::hash_t  v_next;
  shs_pkg::word_t  w_new;
  shs_pkg::taps_t  taps;

  logic [511:0] blk;
  logic [5:0]   fill;
  logic [60:0]  msg_len;
  logic [63:0]  len_bits;
  logic [5:0]   rnd;
  logic [2:0]   out_idx;
  logic         finishing;
  logic         pad_first;
  logic         tail_ok;
  logic         final_blk;

  logic         in_fire;
  logic         out_fire;
  logic         len_phase;
  logic [7:0]   pad_byte;

  assign in_ready    = (state == shs_pkg::ST_IDLE);
  assign out_valid   = (state == shs_pkg::ST_OUT);
  assign in_fire     = in_valid && in_ready;
  assign out_fire    = out_valid && out_ready;
  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign last        = (out_idx == shs_pkg::WORD_LAST);

  assign len_phase = tail_ok && !pad_first && (fill >= shs_pkg::LEN_START);
  assign pad_byte  = pad_first ? shs_pkg::PAD_BYTE :
                     len_phase ? len_bits[63:56] : shs_pkg::ZERO_BYTE;

  assign taps.w0  = blk[511:480];
  assign taps.w1  = blk[479:448];
  assign taps.w9  = blk[223:192];
  assign taps.w14 = blk[63:32];

  shs_round u_round (
    .v      (v),
    .k      (shs_pkg::ROUND_K[rnd]),
    .taps   (taps),
    .v_next (v_next),
    .w_new  (w_new)
  );

  always_ff @(posedge clk) begin
    case (state)
      shs_pkg::ST_IDLE: begin
        if (in_fire && kind == shs_pkg::KIND_DATA) begin
          blk <= {blk[503:0], data_byte};
          fill <= fill + 6'd1;
          msg_len <= msg_len + 61'd1;
          if (fill == shs_pkg::FILL_LAST) begin
            v <= hash;
            rnd <= '0;
            final_blk <= 1'b0;
            state <= shs_pkg::ST_COMP;
          end
        end else if (in_fire) begin
          len_bits <= {msg_len, 3'b000};
          msg_len <= '0;
          finishing <= 1'b1;
          pad_first <= 1'b1;
          tail_ok <= (fill < shs_pkg::LEN_START);
          state <= shs_pkg::ST_PAD;
        end
      end
      shs_pkg::ST_PAD: begin
        blk <= {blk[503:0], pad_byte};
        fill <= fill + 6'd1;
        pad_first <= 1'b0;
        if (len_phase) begin
          len_bits <= {len_bits[55:0], 8'h00};
        end
        if (fill == shs_pkg::FILL_LAST) begin
          v <= hash;
          rnd <= '0;
          final_blk <= tail_ok;
          state <= shs_pkg::ST_COMP;
        end
      end
      shs_pkg::ST_COMP: begin
        v <= v_next;
        blk <= {blk[479:0], w_new};
        rnd <= rnd + 6'd1;
        if (rnd == shs_pkg::ROUND_LAST) begin
          state <= shs_pkg::ST_FOLD;
        end
      end
      shs_pkg::ST_FOLD: begin
        for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
          hash[i] <= hash[i] + v[i];
        end
        if (final_blk) begin
          out_idx <= '0;
          state <= shs_pkg::ST_OUT;
        end else if (finishing) begin
          tail_ok <= 1'b1;
          state <= shs_pkg::ST_PAD;
        end else begin
          state <= shs_pkg::ST_IDLE;
        end
      end
      shs_pkg::ST_OUT: begin
        if (out_fire) begin
          out_idx <= out_idx + 3'd1;
          if (out_idx == shs_pkg::WORD_LAST) begin
            hash <= shs_pkg::INIT_HASH;
            fill <= '0;
            finishing <= 1'b0;
            state <= shs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state <= shs_pkg::ST_IDLE;
      end
    endcase

    if (rst) begin
      state <= shs_pkg::ST_IDLE;
      hash <= shs_pkg::INIT_HASH;
      fill <= '0;
      msg_len <= '0;
      rnd <= '0;
      out_idx <= '0;
      finishing <= 1'b0;
      pad_first <= 1'b0;
      tail_ok <= 1'b0;
      final_blk <= 1'b0;
    end
  end

endmodule
